[design/cjv_pkg.sv]
// ----------------------------------------------------------------------------
// cjv_pkg
// Shared types, widths and constants of the corner junction velocity core.
// ----------------------------------------------------------------------------
package cjv_pkg;

  localparam int CW  = 32;   // coordinate width
  localparam int DW  = 33;   // difference vector component width
  localparam int NW  = 16;   // normalized component width (signed)
  localparam int SQW = 64;   // squared cross product width
  localparam int RW  = 32;   // square root width
  localparam int DOTW = 34;  // dot product width
  localparam int XW  = 36;   // CORDIC x/y width
  localparam int ZW  = 26;   // CORDIC angle accumulator width, Q8.16 degrees
  localparam int AW  = 16;   // corner angle width, Q8.8 degrees
  localparam int VW  = 20;   // velocity width

  localparam logic [AW-1:0] ANG_90_Q8  = 16'd23040;
  localparam logic [AW-1:0] ANG_180_Q8 = 16'd46080;
  localparam logic signed [ZW-1:0] ANG_90_Q16 = 26'sd5898240;

  // floor(q / 45) = (q * VEL_RECIP) >> 32 for every q below 2^28.
  localparam logic [26:0] VEL_RECIP = 27'd95443718;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] junction_x;
    logic signed [CW-1:0] junction_y;
    logic signed [CW-1:0] junction_z;
    logic signed [CW-1:0] next_end_x;
    logic signed [CW-1:0] next_end_y;
    logic signed [CW-1:0] next_end_z;
  } in_item_t;

  typedef struct packed {
    logic [AW-1:0] corner_angle;
    logic [VW-1:0] end_velocity;
    logic          stop_required;
  } out_item_t;

  // Control that travels alongside each item through the pipeline.
  typedef struct packed {
    logic vld;
    logic zero;
  } ctl_t;

  // Arc tangent of 2^-i in Q8.16 degrees.
  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      5'd0:  v = 26'sd2949120;
      5'd1:  v = 26'sd1740967;
      5'd2:  v = 26'sd919879;
      5'd3:  v = 26'sd466945;
      5'd4:  v = 26'sd234379;
      5'd5:  v = 26'sd117304;
      5'd6:  v = 26'sd58666;
      5'd7:  v = 26'sd29335;
      5'd8:  v = 26'sd14668;
      5'd9:  v = 26'sd7334;
      5'd10: v = 26'sd3667;
      5'd11: v = 26'sd1833;
      5'd12: v = 26'sd917;
      5'd13: v = 26'sd458;
      5'd14: v = 26'sd229;
      5'd15: v = 26'sd115;
      5'd16: v = 26'sd57;
      5'd17: v = 26'sd29;
      5'd18: v = 26'sd14;
      5'd19: v = 26'sd7;
      5'd20: v = 26'sd4;
      5'd21: v = 26'sd2;
      5'd22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/corner_junction_velocity_core.sv]
// Throughput: one item per cycle while the output is not stalled; the whole
// pipeline advances together.
// The rate is set by the 32-cell square root chain and the CORDIC cell chain,
// each cell doing one step per cycle on a different item.
// Reset (synchronous, active low) clears all stage valid bits and sets
// max_velocity to 0; payload registers are not reset.
// ----------------------------------------------------------------------------
// corner_junction_velocity_core
// Corner angle and permitted end velocity at a line-to-line junction.
// ----------------------------------------------------------------------------
module corner_junction_velocity_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  cjv_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output cjv_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [19:0]        cfg_data
);
  import cjv_pkg::*;

  // The pipeline moves whenever the output register is empty or being drained.
  logic adv;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  // Configuration register.
  logic [VW-1:0] max_vel_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_vel_r <= '0;
    end else if (cfg_valid) begin
      max_vel_r <= cfg_data;
    end
  end

  // Front: difference vectors, normalizing, products, sums, squares.
  // ctl_r[0] follows the difference stage, ctl_r[1..6] the later front stages.
  ctl_t ctl_r [7];
  logic signed [DW-1:0] va_r [3];
  logic signed [DW-1:0] vb_r [3];
  logic signed [NW-1:0] na [3];
  logic signed [NW-1:0] nb [3];
  ctl_t ctl0_nxt;

  always_comb begin
    ctl0_nxt.vld  = in_valid;
    ctl0_nxt.zero = (in_item.start_x == in_item.junction_x &&
                     in_item.start_y == in_item.junction_y &&
                     in_item.start_z == in_item.junction_z) ||
                    (in_item.next_end_x == in_item.junction_x &&
                     in_item.next_end_y == in_item.junction_y &&
                     in_item.next_end_z == in_item.junction_z);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 7; k++) ctl_r[k] <= '0;
    end else if (adv) begin
      ctl_r[0] <= ctl0_nxt;
      for (int k = 1; k < 7; k++) ctl_r[k] <= ctl_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      va_r[0] <= DW'(in_item.start_x) - DW'(in_item.junction_x);
      va_r[1] <= DW'(in_item.start_y) - DW'(in_item.junction_y);
      va_r[2] <= DW'(in_item.start_z) - DW'(in_item.junction_z);
      vb_r[0] <= DW'(in_item.next_end_x) - DW'(in_item.junction_x);
      vb_r[1] <= DW'(in_item.next_end_y) - DW'(in_item.junction_y);
      vb_r[2] <= DW'(in_item.next_end_z) - DW'(in_item.junction_z);
    end
  end

  // Each normalizer is two stages deep (ctl_r[1], ctl_r[2]).
  cjv_norm u_norm_a (.clk(clk), .en(adv), .vec_in(va_r), .vec_out(na));
  cjv_norm u_norm_b (.clk(clk), .en(adv), .vec_in(vb_r), .vec_out(nb));

  // Nine component products (ctl_r[3]).
  logic signed [31:0] p_r [9];
  always_ff @(posedge clk) begin
    if (adv) begin
      p_r[0] <= na[0] * nb[0];
      p_r[1] <= na[1] * nb[1];
      p_r[2] <= na[2] * nb[2];
      p_r[3] <= na[1] * nb[2];
      p_r[4] <= na[2] * nb[1];
      p_r[5] <= na[2] * nb[0];
      p_r[6] <= na[0] * nb[2];
      p_r[7] <= na[0] * nb[1];
      p_r[8] <= na[1] * nb[0];
    end
  end

  // Dot product and cross product components (ctl_r[4]). The dot product is
  // then delayed to stay beside the cross product square sum.
  logic signed [DOTW-1:0] dot_r [3];
  logic signed [32:0]     cr_r [3];
  always_ff @(posedge clk) begin
    if (adv) begin
      dot_r[0] <= DOTW'(p_r[0]) + DOTW'(p_r[1]) + DOTW'(p_r[2]);
      cr_r[0]  <= 33'(p_r[3]) - 33'(p_r[4]);
      cr_r[1]  <= 33'(p_r[5]) - 33'(p_r[6]);
      cr_r[2]  <= 33'(p_r[7]) - 33'(p_r[8]);
      dot_r[1] <= dot_r[0];
      dot_r[2] <= dot_r[1];
    end
  end

  // Squares of the cross components (ctl_r[5]), then their sum (ctl_r[6]).
  logic [SQW-1:0] sq_r [3];
  logic [31:0]    cmag [3];
  logic [SQW-1:0] sqsum_r;

  always_comb begin
    logic signed [32:0] t;
    for (int k = 0; k < 3; k++) begin
      t = cr_r[k];
      if (t < 0) t = -t;
      cmag[k] = t[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) sq_r[k] <= SQW'(cmag[k]) * SQW'(cmag[k]);
      sqsum_r  <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  // Square root: one cell per result bit.
  ctl_t                   sq_ctl  [RW+1];
  logic [SQW-1:0]         sq_num  [RW+1];
  logic [SQW-1:0]         sq_root [RW+1];
  logic signed [DOTW-1:0] sq_dot  [RW+1];

  assign sq_ctl[0]  = ctl_r[6];
  assign sq_num[0]  = sqsum_r;
  assign sq_root[0] = '0;
  assign sq_dot[0]  = dot_r[2];

  for (genvar g = 0; g < RW; g++) begin : g_sqrt
    cjv_isqrt_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .ctl_in(sq_ctl[g]), .num_in(sq_num[g]), .root_in(sq_root[g]), .dot_in(sq_dot[g]),
      .ctl_out(sq_ctl[g+1]), .num_out(sq_num[g+1]), .root_out(sq_root[g+1]),
      .dot_out(sq_dot[g+1])
    );
  end

  // CORDIC start point. A negative dot product is pre-rotated by -90 degrees.
  ctl_t                 cd_ctl [CORDIC_STAGES+1];
  logic signed [XW-1:0] cd_x   [CORDIC_STAGES+1];
  logic signed [XW-1:0] cd_y   [CORDIC_STAGES+1];
  logic signed [ZW-1:0] cd_z   [CORDIC_STAGES+1];

  ctl_t                 ci_ctl_r;
  logic signed [XW-1:0] ci_x_r, ci_y_r;
  logic signed [ZW-1:0] ci_z_r;
  logic signed [XW-1:0] c_ext, dot_ext;

  assign c_ext   = $signed(XW'(sq_root[RW][RW-1:0]));
  assign dot_ext = XW'(sq_dot[RW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ci_ctl_r <= '0;
    end else if (adv) begin
      ci_ctl_r <= sq_ctl[RW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (sq_dot[RW] < 0) begin
        ci_x_r <= c_ext;
        ci_y_r <= -dot_ext;
        ci_z_r <= ANG_90_Q16;
      end else begin
        ci_x_r <= dot_ext;
        ci_y_r <= c_ext;
        ci_z_r <= '0;
      end
    end
  end

  assign cd_ctl[0] = ci_ctl_r;
  assign cd_x[0]   = ci_x_r;
  assign cd_y[0]   = ci_y_r;
  assign cd_z[0]   = ci_z_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    cjv_cordic_cell #(.IDX(g)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(adv),
      .ctl_in(cd_ctl[g]), .x_in(cd_x[g]), .y_in(cd_y[g]), .z_in(cd_z[g]),
      .ctl_out(cd_ctl[g+1]), .x_out(cd_x[g+1]), .y_out(cd_y[g+1]), .z_out(cd_z[g+1])
    );
  end

  // Rounding and clamping of the angle, stop decision.
  logic signed [ZW-1:0] z_rnd;
  logic [AW-1:0]        ang_nxt;
  always_comb begin
    z_rnd = (cd_z[CORDIC_STAGES] + ZW'(128)) >>> 8;
    if (cd_ctl[CORDIC_STAGES].zero)            ang_nxt = ANG_90_Q8;
    else if (z_rnd < 0)                        ang_nxt = '0;
    else if (z_rnd > $signed(ZW'(ANG_180_Q8))) ang_nxt = ANG_180_Q8;
    else                                       ang_nxt = z_rnd[AW-1:0];
  end

  logic          f_vld_r [3];
  logic [AW-1:0] f_ang_r [3];
  logic          f_stop_r [3];
  logic [AW-1:0] f_diff_r;
  logic [35:0]   f_prod_r;
  logic [53:0]   f_quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) f_vld_r[k] <= 1'b0;
    end else if (adv) begin
      f_vld_r[0] <= cd_ctl[CORDIC_STAGES].vld;
      f_vld_r[1] <= f_vld_r[0];
      f_vld_r[2] <= f_vld_r[1];
    end
  end

  // Velocity = max_velocity * (A - 90 deg) / 90 deg, with the divide by 23040
  // done as a shift by 9 followed by a reciprocal multiply for 45.
  always_ff @(posedge clk) begin
    if (adv) begin
      f_ang_r[0]  <= ang_nxt;
      f_stop_r[0] <= ang_nxt <= ANG_90_Q8;
      f_diff_r    <= (ang_nxt <= ANG_90_Q8) ? '0 : ang_nxt - ANG_90_Q8;
      f_ang_r[1]  <= f_ang_r[0];
      f_stop_r[1] <= f_stop_r[0];
      f_prod_r    <= 36'(max_vel_r) * 36'(f_diff_r);
      f_ang_r[2]  <= f_ang_r[1];
      f_stop_r[2] <= f_stop_r[1];
      f_quo_r     <= 54'(f_prod_r[35:9]) * 54'(VEL_RECIP);
    end
  end

  // Output register.
  logic      out_valid_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_vld_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item_r.corner_angle  <= f_ang_r[2];
      out_item_r.end_velocity  <= f_quo_r[51:32];
      out_item_r.stop_required <= f_stop_r[2];
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A stop corner never carries a velocity.
  a_stop_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_item.stop_required || out_item.end_velocity == '0))
    else $error("stop corner with nonzero velocity");

  // The stop flag agrees with the reported angle.
  a_stop_angle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.stop_required == (out_item.corner_angle <= ANG_90_Q8)))
    else $error("stop flag disagrees with angle");

  // The angle never leaves the clamped range.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.corner_angle <= ANG_180_Q8)
    else $error("corner angle out of range");

  // A held result freezes the pipeline so no item can overtake it.
  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while output stalled");

endmodule

[design/cjv_norm.sv]
// ----------------------------------------------------------------------------
// cjv_norm
// Two-stage vector normalizer: scales all three components by one power of
// two so that the largest magnitude lands in [2^14, 2^15).
// ----------------------------------------------------------------------------
module cjv_norm (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [cjv_pkg::DW-1:0] vec_in  [3],
  output logic signed [cjv_pkg::NW-1:0] vec_out [3]
);
  import cjv_pkg::*;

  logic [DW-1:0] mag_r [3];
  logic          neg_r [3];
  logic [DW-1:0] max_r;

  logic [DW-1:0] mag_nxt [3];
  logic [DW-1:0] max_nxt;
  logic [5:0]    msb;
  logic signed [NW-1:0] vec_nxt [3];
  logic signed [NW-1:0] vec_r [3];

  always_comb begin
    logic signed [DW:0] wide;
    for (int k = 0; k < 3; k++) begin
      wide = {vec_in[k][DW-1], vec_in[k]};
      if (wide < 0) wide = -wide;
      mag_nxt[k] = wide[DW-1:0];
    end
    max_nxt = mag_nxt[0];
    if (mag_nxt[1] > max_nxt) max_nxt = mag_nxt[1];
    if (mag_nxt[2] > max_nxt) max_nxt = mag_nxt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        mag_r[k] <= mag_nxt[k];
        neg_r[k] <= vec_in[k][DW-1];
      end
      max_r <= max_nxt;
    end
  end

  // Position of the leading one of the largest magnitude.
  always_comb begin
    msb = '0;
    for (int k = 0; k < DW; k++) begin
      if (max_r[k]) msb = 6'(k);
    end
  end

  always_comb begin
    logic [DW-1:0] sh;
    for (int k = 0; k < 3; k++) begin
      if (msb >= 6'd14) sh = mag_r[k] >> (msb - 6'd14);
      else              sh = mag_r[k] << (6'd14 - msb);
      vec_nxt[k] = neg_r[k] ? -$signed({1'b0, sh[NW-2:0]}) : $signed({1'b0, sh[NW-2:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) vec_r[k] <= vec_nxt[k];
    end
  end

  assign vec_out = vec_r;

endmodule

[design/cjv_isqrt_cell.sv]
// ----------------------------------------------------------------------------
// cjv_isqrt_cell
// One digit of a restoring integer square root; the dot product and the item
// control ride along unchanged.
// ----------------------------------------------------------------------------
module cjv_isqrt_cell #(
  parameter int IDX = 0
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  cjv_pkg::ctl_t                   ctl_in,
  input  logic [cjv_pkg::SQW-1:0]         num_in,
  input  logic [cjv_pkg::SQW-1:0]         root_in,
  input  logic signed [cjv_pkg::DOTW-1:0] dot_in,
  output cjv_pkg::ctl_t                   ctl_out,
  output logic [cjv_pkg::SQW-1:0]         num_out,
  output logic [cjv_pkg::SQW-1:0]         root_out,
  output logic signed [cjv_pkg::DOTW-1:0] dot_out
);
  import cjv_pkg::*;

  localparam logic [SQW-1:0] BIT = SQW'(1) << (SQW - 2 - 2 * IDX);

  ctl_t                   ctl_r;
  logic [SQW-1:0]         num_r, num_nxt;
  logic [SQW-1:0]         root_r, root_nxt;
  logic signed [DOTW-1:0] dot_r;
  logic [SQW-1:0]         trial;

  always_comb begin
    trial = root_in + BIT;
    if (num_in >= trial) begin
      num_nxt  = num_in - trial;
      root_nxt = (root_in >> 1) + BIT;
    end else begin
      num_nxt  = num_in;
      root_nxt = root_in >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r  <= num_nxt;
      root_r <= root_nxt;
      dot_r  <= dot_in;
    end
  end

  assign ctl_out  = ctl_r;
  assign num_out  = num_r;
  assign root_out = root_r;
  assign dot_out  = dot_r;

endmodule

[design/cjv_cordic_cell.sv]
// ----------------------------------------------------------------------------
// cjv_cordic_cell
// One CORDIC vectoring micro-rotation with its own arc tangent constant.
// ----------------------------------------------------------------------------
module cjv_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  cjv_pkg::ctl_t                 ctl_in,
  input  logic signed [cjv_pkg::XW-1:0] x_in,
  input  logic signed [cjv_pkg::XW-1:0] y_in,
  input  logic signed [cjv_pkg::ZW-1:0] z_in,
  output cjv_pkg::ctl_t                 ctl_out,
  output logic signed [cjv_pkg::XW-1:0] x_out,
  output logic signed [cjv_pkg::XW-1:0] y_out,
  output logic signed [cjv_pkg::ZW-1:0] z_out
);
  import cjv_pkg::*;

  localparam logic signed [ZW-1:0] ATAN = atan_q16(5'(IDX));

  ctl_t                 ctl_r;
  logic signed [XW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;

  always_comb begin
    xs = x_in >>> IDX;
    ys = y_in >>> IDX;
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ATAN;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule
